// ----- sv/whds_pkg.sv -----
// Shared types and constants of the word hash store.
package whds_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned WORD_BYTES  = 128;
  localparam int unsigned CHUNK_MAX   = WORD_BYTES - 1;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned POS_W       = $clog2(WORD_BYTES);
  localparam int unsigned SUM_W       = 14;
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned QDEPTH      = 2;

  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_FLUSH = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] text_byte;
    logic [7:0] read_index;
    logic [6:0] read_position;
  } in_t;

  typedef struct packed {
    logic       reply_kind;
    logic [7:0] slot_index;
    logic       was_occupied;
    logic [6:0] word_length;
    logic       entry_valid;
    logic [7:0] entry_byte;
  } out_t;

  // One unit of work handed from the front to the back
  typedef struct packed {
    logic             kind;
    logic             bank;
    logic [POS_W-1:0] len;
    logic [SUM_W-1:0] sum;
    logic [7:0]       idx;
    logic [6:0]       pos;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

// ----- sv/whds_ram.sv -----
// Generic simple dual-port RAM with registered read.
module whds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/whds_queue.sv -----
// Two-entry job queue between front and back.
module whds_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  whds_pkg::job_t push_job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output whds_pkg::job_t head_o
);
  import whds_pkg::*;

  job_t       ent_q [QDEPTH];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(QDEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rp_q];

  // advance pointers and count
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop_i) begin
      rp_d = ~rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= push_job_i;
    end
  end

endmodule

// ----- sv/whds_front.sv -----
// Front: splits the byte stream into chunks and words, queues jobs.
module whds_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  whds_pkg::in_t              item_i,
  output logic                       busy_o,
  input  logic                       q_full_i,
  output logic                       push_o,
  output whds_pkg::job_t             push_job_o,
  input  whds_pkg::rel_t             rel_i,
  output logic                       wb_we_o,
  output logic [whds_pkg::POS_W:0]   wb_addr_o,
  output logic [7:0]                 wb_data_o
);
  import whds_pkg::*;

  logic [POS_W-1:0] len_q, len_d, len_a;
  logic [SUM_W-1:0] sum_q, sum_d, sum_a;
  logic [POS_W-1:0] chunk_q, chunk_d, chunk_n;
  logic             skip_q, skip_d;
  logic             bank_q, bank_d;
  logic [1:0]       bank_busy_q, bank_busy_d;
  logic             accept, is_space, is_alnum, app, fin;
  logic [7:0]       b;

  assign busy_o   = q_full_i || bank_busy_q[bank_q];
  assign accept   = start_i && !busy_o;
  assign b        = item_i.text_byte;
  assign is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  assign is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
                    (b >= 8'h61 && b <= 8'h7a);
  assign chunk_n  = chunk_q + 7'd1;

  assign wb_we_o   = accept && app;
  assign wb_addr_o = {bank_q, len_q};
  assign wb_data_o = b;

  // classify the beat and update word state
  always_comb begin
    app         = 1'b0;
    fin         = 1'b0;
    chunk_d     = chunk_q;
    skip_d      = skip_q;
    bank_d      = bank_q;
    bank_busy_d = bank_busy_q;
    push_o      = 1'b0;
    push_job_o  = '0;
    if (accept) begin
      unique case (item_i.mode)
        MODE_TEXT: begin
          if (is_space) begin
            fin     = 1'b1;
            chunk_d = '0;
            skip_d  = 1'b0;
          end else begin
            if (!skip_q) begin
              if (b == 8'h00) begin
                fin    = 1'b1;
                skip_d = 1'b1;
              end else if (is_alnum) begin
                app = (len_q < 7'(CHUNK_MAX));
              end else begin
                fin = 1'b1;
              end
            end
            chunk_d = chunk_n;
            if (chunk_n == 7'(CHUNK_MAX)) begin
              fin     = 1'b1;
              chunk_d = '0;
              skip_d  = 1'b0;
            end
          end
        end
        MODE_FLUSH: begin
          fin     = 1'b1;
          chunk_d = '0;
          skip_d  = 1'b0;
        end
        MODE_READ: begin
          push_o         = 1'b1;
          push_job_o.kind = KIND_READ;
          push_job_o.idx  = item_i.read_index;
          push_job_o.pos  = item_i.read_position;
        end
        default: begin
        end
      endcase
    end
    len_a = app ? len_q + 7'd1 : len_q;
    sum_a = app ? sum_q + {{(SUM_W-8){1'b0}}, b} : sum_q;
    len_d = len_a;
    sum_d = sum_a;
    if (fin) begin
      len_d = '0;
      sum_d = '0;
      if (len_a > 7'd1) begin
        push_o          = 1'b1;
        push_job_o.kind = KIND_STORE;
        push_job_o.bank = bank_q;
        push_job_o.len  = len_a;
        push_job_o.sum  = sum_a;
        bank_busy_d[bank_q] = 1'b1;
        bank_d          = ~bank_q;
      end
    end
    if (rel_i.valid) begin
      bank_busy_d[rel_i.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      sum_q       <= '0;
      chunk_q     <= '0;
      skip_q      <= 1'b0;
      bank_q      <= 1'b0;
      bank_busy_q <= '0;
    end else begin
      len_q       <= len_d;
      sum_q       <= sum_d;
      chunk_q     <= chunk_d;
      skip_q      <= skip_d;
      bank_q      <= bank_d;
      bank_busy_q <= bank_busy_d;
    end
  end

endmodule

// ----- sv/whds_back.sv -----
// Back: hashes stored words, copies them into the table, serves reads.
module whds_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [whds_pkg::SIZE_W-1:0]  table_size_i,
  input  logic                         q_empty_i,
  input  whds_pkg::job_t               head_i,
  output logic                         pop_o,
  output whds_pkg::rel_t               rel_o,
  output logic [whds_pkg::POS_W:0]     wb_raddr_o,
  input  logic [7:0]                   wb_rdata_i,
  output logic                         result_valid_o,
  output whds_pkg::out_t               result_o
);
  import whds_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  localparam int unsigned SB_DEPTH = TABLE_DEPTH * WORD_BYTES;
  localparam int unsigned SB_AW    = $clog2(SB_DEPTH);

  logic [2:0]       state_q, state_d;
  job_t             job_q, job_d;
  logic [SUM_W-1:0] sh_q, sh_d;
  logic [3:0]       bit_q, bit_d;
  logic [SIZE_W-1:0] rem_q, rem_d, rem_s, div;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [POS_W-1:0] cnt_q, cnt_d, wpos_q, wpos_d;
  logic             wpend_q, wpend_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic             res_v_q, res_v_d;
  out_t             res_q, res_d;
  logic             len_we;
  logic [IDX_W-1:0] len_raddr;
  logic [POS_W-1:0] len_rdata;
  logic [SB_AW-1:0] sb_raddr;
  logic [7:0]       sb_rdata;
  logic             rd_v;

  // clamp the modulus into 1..TABLE_DEPTH
  always_comb begin
    if (table_size_i == '0) begin
      div = SIZE_W'(1);
    end else if (table_size_i > SIZE_W'(TABLE_DEPTH)) begin
      div = SIZE_W'(TABLE_DEPTH);
    end else begin
      div = table_size_i;
    end
  end

  assign rem_s = {rem_q[SIZE_W-2:0], sh_q[SUM_W-1]};
  assign rd_v  = valid_q[job_q.idx];

  // sequence the jobs
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    sh_d       = sh_q;
    bit_d      = bit_q;
    rem_d      = rem_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    wpend_d    = 1'b0;
    wpos_d     = wpos_q;
    valid_d    = valid_q;
    res_v_d    = 1'b0;
    res_d      = res_q;
    pop_o      = 1'b0;
    rel_o      = '0;
    len_we     = 1'b0;
    len_raddr  = job_q.idx;
    sb_raddr   = {job_q.idx, job_q.pos};
    wb_raddr_o = {job_q.bank, cnt_q};
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          job_d = head_i;
          sh_d  = head_i.sum;
          bit_d = '0;
          rem_d = '0;
          state_d = (head_i.kind == KIND_READ) ? ST_READ : ST_MOD;
        end
      end
      ST_MOD: begin
        // one quotient bit per cycle
        rem_d = (rem_s >= div) ? rem_s - div : rem_s;
        sh_d  = {sh_q[SUM_W-2:0], 1'b0};
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'(SUM_W - 1)) begin
          slot_d                  = rem_d[IDX_W-1:0];
          len_we                  = 1'b1;
          len_raddr               = rem_d[IDX_W-1:0];
          valid_d[rem_d[IDX_W-1:0]] = 1'b1;
          res_v_d                 = 1'b1;
          res_d                   = '0;
          res_d.reply_kind        = KIND_STORE;
          res_d.slot_index        = 8'(rem_d[IDX_W-1:0]);
          res_d.was_occupied      = valid_q[rem_d[IDX_W-1:0]];
          res_d.word_length       = job_q.len;
          cnt_d                   = '0;
          state_d                 = ST_COPY;
        end
      end
      ST_COPY: begin
        wpend_d = 1'b1;
        wpos_d  = cnt_q;
        cnt_d   = cnt_q + 7'd1;
        if (cnt_q == job_q.len - 7'd1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        rel_o.valid = 1'b1;
        rel_o.bank  = job_q.bank;
        state_d     = ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        res_v_d           = 1'b1;
        res_d             = '0;
        res_d.reply_kind  = KIND_READ;
        res_d.slot_index  = job_q.idx;
        res_d.entry_valid = rd_v;
        res_d.word_length = rd_v ? len_rdata : '0;
        res_d.entry_byte  = (rd_v && job_q.pos < len_rdata) ? sb_rdata : 8'h00;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wpend_q <= 1'b0;
      valid_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wpend_q <= wpend_d;
      valid_q <= valid_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    sh_q   <= sh_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    slot_q <= slot_d;
    cnt_q  <= cnt_d;
    wpos_q <= wpos_d;
    res_q  <= res_d;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // slot lengths
  whds_ram #(.WIDTH(POS_W), .DEPTH(TABLE_DEPTH)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (slot_d),
    .wdata_i (job_q.len),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // slot bytes, one row of WORD_BYTES per slot
  whds_ram #(.WIDTH(8), .DEPTH(SB_DEPTH)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wpend_q),
    .waddr_i ({slot_q, wpos_q}),
    .wdata_i (wb_rdata_i),
    .raddr_i (sb_raddr),
    .rdata_o (sb_rdata)
  );

`ifndef SYNTHESIS
  // results never come in back-to-back cycles
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |=> !res_v_q) else $error("back-to-back results");
  // remainder stays below the modulus while dividing
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> (rem_q < div)) else $error("remainder out of range");
  // no table write left pending when idle
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wpend_q) else $error("pending write in idle");
  // a stored slot is valid after the report
  a_store_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && res_q.reply_kind == KIND_STORE) |-> valid_q[res_q.slot_index])
    else $error("stored slot not valid");
`endif

endmodule

// ----- sv/word_hash_direct_mapped_store_unit.sv -----
// Top level of the word hash store.
// Usage:
//   Items enter on item_i when start_i is high and busy_o is low. mode 0
//   feeds one text byte, mode 1 flushes the pending word, mode 2 reads one
//   byte and the length of a table slot. busy_o rises only while the
//   two-entry job queue is full or while the word buffer bank being filled
//   is still copied into the table. Each result appears on result_o for
//   one cycle with result_valid_o high. With the back idle, a stored word
//   reports after its finishing beat once the job is popped and the
//   remainder unit has run, then its bytes are copied one per cycle while
//   the front keeps collecting the next word in the other bank. With the
//   back idle, a read answers after its beat through pop, RAM read and
//   reply register.
//   table_size is written through the APB port at address 0 while idle;
//   values 0 and above 256 act as 1 and 256.
//   Reset clears all slot valid bits, pending word and chunk state, and sets
//   table_size to 256; no clearing pass is needed.
//   The receiver cannot stall; results are never issued in adjacent cycles.
module word_hash_direct_mapped_store_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  whds_pkg::in_t  item_i,
  output logic           result_valid_o,
  output whds_pkg::out_t result_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import whds_pkg::*;

  logic [SIZE_W-1:0] table_size_q;
  logic              q_full, q_empty, push, pop;
  job_t              push_job, head;
  rel_t              rel;
  logic              wb_we;
  logic [POS_W:0]    wb_waddr, wb_raddr;
  logic [7:0]        wb_wdata, wb_rdata;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-SIZE_W){1'b0}}, table_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SIZE_W'(TABLE_DEPTH);
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      table_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  whds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_job_o (push_job),
    .rel_i      (rel),
    .wb_we_o    (wb_we),
    .wb_addr_o  (wb_waddr),
    .wb_data_o  (wb_wdata)
  );

  // two banks of pending word bytes
  whds_ram #(.WIDTH(8), .DEPTH(2 * WORD_BYTES)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (wb_we),
    .waddr_i (wb_waddr),
    .wdata_i (wb_wdata),
    .raddr_i (wb_raddr),
    .rdata_o (wb_rdata)
  );

  whds_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  whds_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .table_size_i   (table_size_q),
    .q_empty_i      (q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .rel_o          (rel),
    .wb_raddr_o     (wb_raddr),
    .wb_rdata_i     (wb_rdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- tb/sv/tb_word_hash_direct_mapped_store_unit.sv -----
// Self-checking testbench of the word hash store: text, flush and read beats against a predictor.
`timescale 1ns / 100ps

import whds_pkg::*;

// Word store predictor and queue of expected replies
class word_store_board;
  logic [8:0] size_reg;
  logic [7:0] pend_bytes [0:126];
  int unsigned pend_len, pend_sum, chunk_len;
  bit skipping;
  bit slot_ok [0:255];
  int unsigned slot_len [0:255];
  logic [7:0] slot_data [0:255][0:126];
  out_t expected_q [$];
  int errors;

  function new();
    size_reg = 9'd256;
    pend_len = 0; pend_sum = 0; chunk_len = 0; skipping = 0; errors = 0;
    foreach (slot_ok[i]) begin
      slot_ok[i] = 0;
      slot_len[i] = 0;
    end
  endfunction

  // Close the pending word; queue a store report if it is kept
  function bit close_word();
    int unsigned modulus, slot;
    out_t r;
    bit got;
    got = 0;
    if (pend_len > 1) begin
      modulus = (size_reg == 0) ? 1 : ((size_reg > 256) ? 256 : size_reg);
      slot = pend_sum % modulus;
      r = '0;
      r.reply_kind = KIND_STORE;
      r.slot_index = slot[7:0];
      r.was_occupied = slot_ok[slot];
      r.word_length = pend_len[6:0];
      for (int i = 0; i < pend_len; i++) slot_data[slot][i] = pend_bytes[i];
      slot_len[slot] = pend_len;
      slot_ok[slot] = 1;
      expected_q.push_back(r);
      got = 1;
    end
    pend_len = 0;
    pend_sum = 0;
    return got;
  endfunction

  function void note_item(in_t it);
    logic [7:0] b;
    bit got;
    out_t r;
    b = it.text_byte;
    got = 0;
    case (it.mode)
      MODE_TEXT: begin
        if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0d)) begin
          void'(close_word());
          chunk_len = 0;
          skipping = 0;
          return;
        end
        if (!skipping) begin
          if (b == 8'h00) begin
            got = close_word();
            skipping = 1;
          end else if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
                       (b >= "a" && b <= "z")) begin
            if (pend_len < 127) begin
              pend_bytes[pend_len] = b;
              pend_len++;
              pend_sum += b;
            end
          end else begin
            got = close_word();
          end
        end
        chunk_len++;
        if (chunk_len >= 127) begin
          if (!got) void'(close_word());
          chunk_len = 0;
          skipping = 0;
        end
      end
      MODE_FLUSH: begin
        void'(close_word());
        chunk_len = 0;
        skipping = 0;
      end
      MODE_READ: begin
        r = '0;
        r.reply_kind = KIND_READ;
        r.slot_index = it.read_index;
        if (slot_ok[it.read_index]) begin
          r.entry_valid = 1;
          r.word_length = slot_len[it.read_index][6:0];
          if (it.read_position < slot_len[it.read_index])
            r.entry_byte = slot_data[it.read_index][it.read_position];
        end
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void check_reply(out_t act);
    out_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected reply %h", act);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (act.reply_kind !== e.reply_kind) begin
      $error("reply_kind exp %h act %h", e.reply_kind, act.reply_kind); errors++;
    end
    if (act.slot_index !== e.slot_index) begin
      $error("slot_index exp %h act %h", e.slot_index, act.slot_index); errors++;
    end
    if (act.was_occupied !== e.was_occupied) begin
      $error("was_occupied exp %h act %h", e.was_occupied, act.was_occupied); errors++;
    end
    if (act.word_length !== e.word_length) begin
      $error("word_length exp %h act %h", e.word_length, act.word_length); errors++;
    end
    if (act.entry_valid !== e.entry_valid) begin
      $error("entry_valid exp %h act %h", e.entry_valid, act.entry_valid); errors++;
    end
    if (act.entry_byte !== e.entry_byte) begin
      $error("entry_byte exp %h act %h", e.entry_byte, act.entry_byte); errors++;
    end
  endfunction
endclass

module tb_word_hash_direct_mapped_store_unit;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic busy_o;
  in_t item_i = '0;
  logic result_valid_o;
  out_t result_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  word_store_board board = new();
  int idle_cycles = 0;

  word_hash_direct_mapped_store_unit uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Check each reply beat and watch for a stalled run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) board.check_reply(result_o);
      if (result_valid_o || (start_i && !busy_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("word_hash_direct_mapped_store_unit: mismatch");
        $finish;
      end
    end
  end

  // Idle gap, mostly short, sometimes long; drop start while idling
  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) begin
      start_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Send one item and hold until the block accepts it; start stays high
  // until an idle wait drops it
  task automatic send(in_t it);
    start_i <= 1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    board.note_item(it);
  endtask

  task automatic send_text(logic [7:0] b);
    in_t it;
    it = '0;
    it.mode = MODE_TEXT;
    it.text_byte = b;
    if ($urandom_range(0, 1)) it.read_index = 8'($urandom);
    send(it);
  endtask

  task automatic send_mode(logic [1:0] m, logic [7:0] idx, logic [6:0] pos);
    in_t it;
    it = '0;
    it.mode = m;
    it.read_index = idx;
    it.read_position = pos;
    it.text_byte = 8'($urandom);
    send(it);
  endtask

  // Read a slot, written or not
  task automatic read_slot(logic [7:0] idx, logic [6:0] pos);
    send_mode(MODE_READ, idx, pos);
  endtask

  // Let the block go idle, then write table_size
  task automatic set_size(logic [8:0] val);
    start_i <= 0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= {$urandom} & ~32'h1ff | val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    board.size_reg = val;
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] alnum();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      default: return 8'($urandom_range("0", "9"));
    endcase
  endfunction

  function automatic logic [7:0] space_byte();
    return ($urandom_range(0, 1)) ? 8'h20 : 8'($urandom_range(9, 13));
  endfunction

  // One word of random length and a random separator
  task automatic word_beats(int len);
    int k;
    for (int i = 0; i < len; i++) begin
      send_text(alnum());
      if ($urandom_range(0, 4) == 0) gap();
    end
    k = $urandom_range(0, 19);
    if (k < 12) send_text(space_byte());
    else if (k < 15) send_text(8'($urandom_range(33, 47)));
    else if (k < 16) send_text(8'h00);
    else if (k < 17) send_text(8'($urandom_range(128, 255)));
    else if (k < 18) send_mode(MODE_FLUSH, 8'($urandom), 7'($urandom));
    else send_text(8'($urandom));
  endtask

  task automatic random_phase(int count);
    int sent, r, n;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(1, ($urandom_range(0, 15) == 0) ? 140 : 10);
        word_beats(n);
        sent += n + 1;
      end else if (r < 85) begin
        read_slot(8'($urandom),
                  ($urandom_range(0, 1)) ? 7'($urandom_range(0, 12)) : 7'($urandom));
        sent++;
      end else if (r < 97) begin
        send_text(8'($urandom));
        sent++;
      end else begin
        send_mode($urandom_range(0, 1) ? MODE_FLUSH : 2'd3, 8'($urandom), 7'($urandom));
        sent++;
      end
      if ($urandom_range(0, 2) == 0) gap();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: short words, extremes, zero byte, full chunk, reads, unused mode
    send_text("a"); send_text(" ");
    send_text("z"); send_text("Z"); send_text(8'h09);
    send_text("0"); send_text("9"); send_text("!");
    send_text("A"); send_text("b"); send_text(8'h00);
    send_text("q"); send_text("r"); send_text(" ");
    send_text("x"); send_text("y"); send_mode(MODE_FLUSH, 0, 0);
    send_text(8'hff); send_text(8'h80);
    send_mode(2'd3, 8'hff, 7'h7f);
    read_slot(8'(("z" + "Z") % 256), 0);
    read_slot(8'(("z" + "Z") % 256), 7'h7f);
    for (int i = 0; i < 130; i++) send_text(alnum());
    send_mode(MODE_FLUSH, 0, 0);
    for (int i = 0; i < 256; i++) read_slot(i[7:0], 7'd126);

    random_phase(390);
    set_size(9'd1);
    random_phase(160);
    set_size(9'd0);
    random_phase(120);
    set_size(9'd511);
    random_phase(160);
    set_size(9'd257);
    random_phase(120);
    set_size(9'($urandom_range(2, 255)));
    random_phase(270);
    set_size(9'd256);
    random_phase(220);
    send_mode(MODE_FLUSH, 0, 0);
    start_i <= 0;

    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0)
      $display("word_hash_direct_mapped_store_unit: match");
    else
      $display("word_hash_direct_mapped_store_unit: mismatch");
    $finish;
  end
endmodule
